>>> sv/lz77wd_pkg.sv
// Shared constants for the LZ77 window decompressor: parse phase codes,
// pair field widths and the configuration register map.
// No dependencies.
package lz77wd_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SIZE0 = 3'd1;
  localparam logic [2:0] PH_SIZE1 = 3'd2;
  localparam logic [2:0] PH_SIZE2 = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_PAIR  = 3'd5;

  // Pair encoding: 4-bit length field plus bias, 12-bit distance plus one
  localparam int unsigned LenW     = 5;
  localparam int unsigned DistW    = 13;
  localparam int unsigned LenBias  = 3;
  localparam logic [3:0]  FlagNeed = 4'd8;

  // Configuration port
  localparam int unsigned PaddrW        = 3;
  localparam logic        REG_FILL_BYTE = 1'b0;
  localparam logic [7:0]  FillReset     = 8'h20;

endpackage

>>> sv/lz77wd_in_if.sv
// Input channel of the decompressor: one compressed byte per word.
// No dependencies.
interface lz77wd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink (input valid, input in_byte, input stream_start, output ready);
endinterface

>>> sv/lz77wd_out_if.sv
// Output channel of the decompressor: one decompressed byte per word.
// No dependencies.
interface lz77wd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_end;
  logic       used_fill;

  modport source (output valid, output out_byte, output last_of_run,
                  output stream_end, output used_fill, input ready);
  modport sink (input valid, input out_byte, input last_of_run,
                input stream_end, input used_fill, output ready);
endinterface

>>> sv/lz77wd_hist_mem.sv
// History window: single write port, one registered read port, with
// forwarding of a write to the same entry in the read cycle.
// No package dependencies.
module lz77wd_hist_mem #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [WINDOW_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q    <= mem_q[raddr_i];
      // array still holds the old byte when both ports hit one entry
      fwd_q      <= we_i && (waddr_i == raddr_i);
      fwd_data_q <= wdata_i;
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

>>> sv/lz77wd_engine.sv
// Stream parser and copy sequencer: header, flag and pair decode, a history
// write per output byte and a read per copied byte, and the output register.
// Depends on lz77wd_pkg and the two channel interfaces.
module lz77wd_engine
  import lz77wd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 4096,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    fill_byte_i,
  lz77wd_in_if.sink     in_i,
  lz77wd_out_if.source  out_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [7:0]    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [7:0]    mem_rdata_i
);

  logic [2:0]       phase_q;
  logic [23:0]      target_q;
  logic [23:0]      pos_q;
  logic [7:0]       flag_bits_q;
  logic [3:0]       flag_idx_q;
  logic [7:0]       pair_first_q;
  logic             copy_q;
  logic [LenW-1:0]  rem_q;
  logic [DistW-1:0] dist_q;
  logic             fill_pend_q;
  logic             ov_q;
  logic [7:0]       ob_q;
  logic             olast_q;
  logic             oend_q;
  logic             ofill_q;

  logic             out_free, in_ready, acc, flag_bit;
  logic             lit_emit, pair_go, copy_emit, copy_more, emit, hit_end;
  logic [7:0]       emit_byte;
  logic [23:0]      pos_inc;
  logic [LenW-1:0]  pair_len;
  logic [DistW-1:0] pair_dist;

  always_comb begin
    out_free  = !ov_q || out_o.ready;
    in_ready  = !copy_q && out_free;
    acc       = in_i.valid && in_ready;
    flag_bit  = flag_bits_q[3'd7 - flag_idx_q[2:0]];
    pair_len  = {1'b0, pair_first_q[7:4]} + LenW'(LenBias);
    pair_dist = {1'b0, pair_first_q[3:0], in_i.in_byte} + DistW'(1);
    lit_emit  = acc && !in_i.stream_start && (phase_q == PH_DATA) &&
                !flag_idx_q[3] && !flag_bit;
    pair_go   = acc && !in_i.stream_start && (phase_q == PH_PAIR);
    copy_emit = copy_q && out_free;
    emit      = lit_emit || copy_emit;
    emit_byte = copy_q ? (fill_pend_q ? fill_byte_i : mem_rdata_i) : in_i.in_byte;
    pos_inc   = pos_q + 24'd1;
    hit_end   = (pos_inc == target_q);
    copy_more = copy_emit && !hit_end && (rem_q != LenW'(1));

    mem_we_o    = emit;
    mem_waddr_o = pos_q[AW-1:0];
    mem_wdata_o = emit_byte;
    mem_re_o    = pair_go || copy_more;
    mem_raddr_o = pair_go ? (pos_q[AW-1:0] - pair_dist[AW-1:0])
                          : (pos_inc[AW-1:0] - dist_q[AW-1:0]);
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      target_q     <= '0;
      pos_q        <= '0;
      flag_bits_q  <= '0;
      flag_idx_q   <= FlagNeed;
      pair_first_q <= '0;
      copy_q       <= 1'b0;
      rem_q        <= '0;
      dist_q       <= '0;
      fill_pend_q  <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      if (acc) begin
        if (in_i.stream_start) begin
          pos_q        <= '0;
          target_q     <= '0;
          flag_bits_q  <= '0;
          flag_idx_q   <= FlagNeed;
          pair_first_q <= '0;
          phase_q      <= PH_SIZE0;
        end else begin
          unique case (phase_q)
            PH_SIZE0: begin
              target_q <= {16'd0, in_i.in_byte};
              phase_q  <= PH_SIZE1;
            end
            PH_SIZE1: begin
              target_q[15:8] <= in_i.in_byte;
              phase_q        <= PH_SIZE2;
            end
            PH_SIZE2: begin
              target_q[23:16] <= in_i.in_byte;
              phase_q <= ({in_i.in_byte, target_q[15:0]} == 24'd0) ? PH_IDLE : PH_DATA;
            end
            PH_DATA: begin
              if (flag_idx_q[3]) begin
                flag_bits_q <= in_i.in_byte;
                flag_idx_q  <= '0;
              end else if (!flag_bit) begin
                flag_idx_q <= flag_idx_q + 4'd1;
              end else begin
                pair_first_q <= in_i.in_byte;
                phase_q      <= PH_PAIR;
              end
            end
            PH_PAIR: begin
              phase_q     <= PH_DATA;
              flag_idx_q  <= flag_idx_q + 4'd1;
              copy_q      <= 1'b1;
              rem_q       <= pair_len;
              dist_q      <= pair_dist;
              fill_pend_q <= (pos_q < {11'd0, pair_dist});
            end
            default: ;
          endcase
        end
      end

      if (emit) begin
        pos_q <= pos_inc;
        if (hit_end) begin
          phase_q <= PH_IDLE;
        end
      end

      // advance the copy, or stop at its length or at the declared size
      if (copy_emit) begin
        if (copy_more) begin
          rem_q       <= rem_q - LenW'(1);
          fill_pend_q <= (pos_inc < {11'd0, dist_q});
        end else begin
          copy_q <= 1'b0;
        end
      end

      if (out_free) begin
        ov_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      ob_q    <= emit_byte;
      olast_q <= !copy_more;
      oend_q  <= hit_end;
      ofill_q <= copy_q && fill_pend_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.out_byte    = ob_q;
  assign out_o.last_of_run = olast_q;
  assign out_o.stream_end  = oend_q;
  assign out_o.used_fill   = ofill_q;

endmodule

>>> sv/lz77_window_decompressor_core.sv
// LZ77 window decompressor, top level: APB register, parser and history. Header,
// flag and literal words are taken one per cycle while in_ready is high; a literal
// shows on the output the cycle after it is taken. A pair of length L holds the
// input while up to L bytes are copied, one per cycle unless the output stalls;
// the first passes the history read register, then the output register. Reset
// clears the parser and sets fill_byte to 0x20; the history is not cleared.
module lz77_window_decompressor_core
  import lz77wd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 4096,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lz77wd_in_if.sink         in_i,
  lz77wd_out_if.source      out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]    fill_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= FillReset;
    end else if (psel && penable && pwrite && (paddr[2] == REG_FILL_BYTE)) begin
      fill_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_FILL_BYTE) ? {24'd0, fill_q} : 32'd0;

  lz77wd_engine #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fill_byte_i (fill_q),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lz77wd_hist_mem #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> tb/testbench.sv
// Self-checking bench for lz77_window_decompressor_core: fills a word queue with
// directed and random compressed streams, predicts each output byte and compares.
// Depends on lz77wd_pkg and the lz77wd_in_if / lz77wd_out_if channel interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lz77wd_pkg::*;

  localparam int unsigned WindowDepth = 4096;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned SettleWait  = 12;
  localparam int unsigned NoCut       = 32'hFFFF_FFFF;
  localparam logic [PaddrW-1:0] FillAddr = PaddrW'(4 * REG_FILL_BYTE);

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       fill;
  } out_word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lz77wd_in_if  in_ch ();
  lz77wd_out_if out_ch ();

  lz77_window_decompressor_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Decoder state mirrored by the bench
  logic [7:0]  window [WindowDepth];
  logic [23:0] out_pos;
  logic [23:0] out_size;
  logic [2:0]  phase;
  logic [7:0]  flags;
  logic [3:0]  flag_pos;
  logic [7:0]  pair_hi;
  logic [7:0]  fill_now;

  in_word_t  stream_words [$];
  out_word_t expected_bytes [$];

  int unsigned errors;
  int unsigned words_in;
  int unsigned bytes_out;
  int unsigned ends_seen;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;
  int unsigned hold_cnt;
  logic        hold_state;

  function automatic void flag_error(input string what);
    errors++;
    if (errors <= 10) $display("%0t ERROR %s", $realtime, what);
  endfunction

  function automatic void put_byte(input logic [7:0] v, input logic f);
    out_word_t w;
    window[out_pos[11:0]] = v;
    out_pos = out_pos + 24'd1;
    w.data = v;
    w.last = 1'b0;
    w.fill = f;
    w.done = (out_pos == out_size);
    if (w.done) phase = PH_IDLE;
    expected_bytes.push_back(w);
  endfunction

  // Work out the output bytes that one accepted compressed word gives
  function automatic void decode_word(input logic [7:0] b, input logic s);
    int unsigned len;
    int unsigned n;
    logic [12:0] back;
    logic [11:0] idx;
    n = 0;
    if (s) begin
      out_pos  = '0;
      out_size = '0;
      flags    = '0;
      flag_pos = FlagNeed;
      pair_hi  = '0;
      phase    = PH_SIZE0;
      return;
    end
    case (phase)
      PH_SIZE0: begin
        out_size = {16'd0, b};
        phase = PH_SIZE1;
      end
      PH_SIZE1: begin
        out_size[15:8] = b;
        phase = PH_SIZE2;
      end
      PH_SIZE2: begin
        out_size[23:16] = b;
        phase = (out_size == 24'd0) ? PH_IDLE : PH_DATA;
      end
      PH_DATA: begin
        if (flag_pos >= FlagNeed) begin
          flags = b;
          flag_pos = '0;
        end else if (!flags[7 - flag_pos]) begin
          flag_pos++;
          put_byte(b, 1'b0);
          n = 1;
        end else begin
          pair_hi = b;
          phase = PH_PAIR;
        end
      end
      PH_PAIR: begin
        len  = pair_hi[7:4] + LenBias;
        back = {1'b0, pair_hi[3:0], b} + 13'd1;
        phase = PH_DATA;
        flag_pos++;
        // stop early once the declared size is reached
        while (len > 0 && phase == PH_DATA) begin
          len--;
          if (out_pos < back) begin
            put_byte(fill_now, 1'b1);
          end else begin
            idx = out_pos[11:0] - back[11:0];
            put_byte(window[idx], 1'b0);
          end
          n++;
        end
      end
      default: ;
    endcase
    if (n > 0) expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  // Driver: bursts of words with random gaps
  always @(posedge clk_i) begin : drive
    in_word_t w;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        decode_word(in_ch.in_byte, in_ch.stream_start);
        words_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || stream_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          w = stream_words.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.in_byte      <= w.data;
          in_ch.stream_start <= w.start;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Monitor: stall pattern varies over the run, check every accepted word
  always @(posedge clk_i) begin : watch
    out_word_t w;
    logic      r;
    if (rst_ni) begin
      if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: r = 1'b1;
        1: r = ($urandom_range(0, 3) != 0);
        2: r = (cycles % 3 != 0);
        default: begin
          if (hold_cnt == 0) begin
            hold_state = !hold_state;
            hold_cnt = hold_state ? $urandom_range(1, 10) : $urandom_range(1, 8);
          end else begin
            hold_cnt--;
          end
          r = hold_state;
        end
      endcase
      if (out_ch.valid && out_ch.ready) begin
        bytes_out++;
        if (out_ch.stream_end) ends_seen++;
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected word: byte %02h last %0b end %0b fill %0b",
                               out_ch.out_byte, out_ch.last_of_run, out_ch.stream_end,
                               out_ch.used_fill));
        end else begin
          w = expected_bytes.pop_front();
          if (out_ch.out_byte !== w.data || out_ch.last_of_run !== w.last ||
              out_ch.stream_end !== w.done || out_ch.used_fill !== w.fill)
            flag_error($sformatf({"expected byte %02h last %0b end %0b fill %0b, ",
                                  "got byte %02h last %0b end %0b fill %0b"},
                                 w.data, w.last, w.done, w.fill,
                                 out_ch.out_byte, out_ch.last_of_run,
                                 out_ch.stream_end, out_ch.used_fill));
        end
      end
      out_ch.ready <= r;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycles,
               expected_bytes.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic cfg_write(input logic [PaddrW-1:0] a, input logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input logic [PaddrW-1:0] a, output logic [31:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    d = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_fill(input logic [7:0] v);
    logic [31:0] rd;
    cfg_write(FillAddr, {24'd0, v});
    fill_now = v;
    cfg_read(FillAddr, rd);
    if (rd[7:0] !== v) flag_error($sformatf("fill_byte read %02h, wrote %02h", rd[7:0], v));
  endtask

  // Hold until the block has drained, then let the pipeline empty
  task automatic settle();
    while (stream_words.size() > 0 || in_ch.valid || expected_bytes.size() > 0)
      @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Queue one stream: header, then flag groups until the size is covered.
  // cut_at truncates the stream to that many words.
  task automatic add_stream(input int unsigned size, input bit long_run,
                            input int unsigned cut_at, output int unsigned n_words);
    in_word_t    words [$];
    int unsigned made;
    logic [7:0]  flag;
    logic [3:0]  len_f;
    logic [11:0] dist_f;
    words.push_back({8'($urandom_range(0, 255)), 1'b1});
    words.push_back({size[7:0], 1'b0});
    words.push_back({size[15:8], 1'b0});
    words.push_back({size[23:16], 1'b0});
    made = 0;
    while (made < size && words.size() < cut_at) begin
      if (long_run && $urandom_range(0, 7) != 0) flag = 8'hFF;
      else flag = 8'($urandom_range(0, 255));
      words.push_back({flag, 1'b0});
      for (int k = 7; k >= 0 && made < size; k--) begin
        if (flag[k]) begin
          len_f = long_run ? 4'hF : 4'($urandom_range(0, 15));
          // mostly reach back into real history, sometimes before the start
          if (long_run || $urandom_range(0, 4) == 0)
            dist_f = 12'($urandom_range(0, 4095));
          else
            dist_f = 12'($urandom_range(0, (made < 4094) ? made + 1 : 4095));
          words.push_back({len_f, dist_f[11:8], 1'b0});
          words.push_back({dist_f[7:0], 1'b0});
          made += len_f + LenBias;
        end else begin
          words.push_back({8'($urandom_range(0, 255)), 1'b0});
          made++;
        end
      end
    end
    while (words.size() > cut_at) void'(words.pop_back());
    n_words = words.size();
    foreach (words[i]) stream_words.push_back(words[i]);
  endtask

  task automatic random_streams(input int unsigned quota);
    int unsigned taken;
    int unsigned n;
    int unsigned pick;
    int unsigned size;
    int unsigned cut;
    taken = 0;
    while (taken < quota) begin
      pick = $urandom_range(0, 19);
      cut  = NoCut;
      if (pick == 0) begin
        size = 0;
      end else if (pick == 1) begin
        size = $urandom_range(32'h01_0000, 32'hFF_FFFF);
        cut  = $urandom_range(6, 30);
      end else if (pick <= 4) begin
        size = $urandom_range(2, 48);
        cut  = $urandom_range(4, 20);
      end else begin
        size = $urandom_range(1, 48);
      end
      add_stream(size, 1'b0, cut, n);
      taken += n;
      // trailing bytes after a finished stream must be dropped by the block
      if (cut == NoCut)
        repeat ($urandom_range(0, 2)) stream_words.push_back({8'($urandom_range(0, 255)), 1'b0});
    end
  endtask

  initial begin : stimulus
    logic [31:0] rd;
    logic [7:0]  fill_last;
    int unsigned n;
    int unsigned long_size;
    clk_i   = 1'b0;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = '0;
    in_ch.stream_start = 1'b0;
    out_ch.ready       = 1'b0;
    out_pos    = '0;
    out_size   = '0;
    phase      = PH_IDLE;
    flags      = '0;
    flag_pos   = FlagNeed;
    pair_hi    = '0;
    fill_now   = FillReset;
    errors     = 0;
    words_in   = 0;
    bytes_out  = 0;
    ends_seen  = 0;
    cycles     = 0;
    burst_left = 1;
    gap_left   = 0;
    stall_mode = 0;
    hold_cnt   = 0;
    hold_state = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_read(FillAddr, rd);
    if (rd[7:0] !== FillReset)
      flag_error($sformatf("fill_byte after reset %02h, want %02h", rd[7:0], FillReset));

    // zero size: header only, then a stray byte
    stream_words.push_back({8'h10, 1'b1});
    stream_words.push_back({8'h00, 1'b0});
    stream_words.push_back({8'h00, 1'b0});
    stream_words.push_back({8'h00, 1'b0});
    stream_words.push_back({8'hAA, 1'b0});
    // size 5: literal, then a long copy at distance one cut by the size
    stream_words.push_back({8'hFF, 1'b1});
    stream_words.push_back({8'h05, 1'b0});
    stream_words.push_back({8'h00, 1'b0});
    stream_words.push_back({8'h00, 1'b0});
    stream_words.push_back({8'h40, 1'b0});
    stream_words.push_back({8'hFF, 1'b0});
    stream_words.push_back({8'hF0, 1'b0});
    stream_words.push_back({8'h00, 1'b0});
    stream_words.push_back({8'h55, 1'b0});
    // largest size: copy from before the start, a literal, then restart
    stream_words.push_back({8'h10, 1'b1});
    stream_words.push_back({8'hFF, 1'b0});
    stream_words.push_back({8'hFF, 1'b0});
    stream_words.push_back({8'hFF, 1'b0});
    stream_words.push_back({8'h80, 1'b0});
    stream_words.push_back({8'h0F, 1'b0});
    stream_words.push_back({8'hFF, 1'b0});
    stream_words.push_back({8'h00, 1'b0});
    settle();

    set_fill(8'hFF);
    random_streams(25);
    settle();

    set_fill(8'h00);
    random_streams(25);
    settle();

    // one stream long enough to wrap the history window
    fill_last = 8'($urandom_range(1, 254));
    set_fill(fill_last);
    long_size = 4200 + $urandom_range(0, 200);
    add_stream(long_size, 1'b1, NoCut, n);
    random_streams(8);
    settle();

    $display("covered %0d input words, %0d output words, %0d streams run to their size",
             words_in, bytes_out, ends_seen);
    $display("fill byte 20, ff, 00 and %02h; window wrapped by a %0d-byte stream",
             fill_last, long_size);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
